// ===== sv/hti_pkg.sv =====
`timescale 1ns / 1ps

package hti_pkg;

  // Grid geometry
  localparam int unsigned GRID_SIZE = 256;
  localparam int unsigned MEM_DEPTH = GRID_SIZE * GRID_SIZE;
  localparam int          MEM_AW    = $clog2(MEM_DEPTH);

  // Field and register widths
  localparam int HGT_W  = 16;
  localparam int PT_W   = 21;
  localparam int IDX_W  = 8;
  localparam int BYTE_W = 8;
  localparam int PPT_W  = 11;
  localparam int ELEV_W = 19;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 11;

  // Datapath widths
  localparam int RR_W     = PPT_W + 1;
  localparam int DIV_STEP = 4;
  localparam int FN_W     = 24;
  localparam int TI_W     = FN_W;
  localparam int FR_DIV   = FN_W / DIV_STEP;
  localparam int DIFF_W   = HGT_W + 1;
  localparam int PROD0_W  = HGT_W + PPT_W;
  localparam int PROD_W   = DIFF_W + RR_W;
  localparam int NUM_W    = PROD_W + 1;
  localparam int BN_W     = 32;
  localparam int BK_DIV   = BN_W / DIV_STEP;

  localparam logic KIND_QUERY = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  localparam logic [CFG_IW-1:0] REG_PPT   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_PAD   = 2'd1;
  localparam logic [CFG_IW-1:0] REG_SCALE = 2'd2;

  typedef enum logic [2:0] {
    ST_LEFT  = 3'b001,
    ST_RIGHT = 3'b010,
    ST_MID   = 3'b100
  } step_t;

  typedef struct packed {
    logic [DIV_STEP-1:0] q;
    logic [PPT_W-1:0]    rem;
  } dstep_t;

  typedef struct packed {
    logic              ok;
    logic [MEM_AW-1:0] addr;
    logic [HGT_W-1:0]  data;
  } wr_t;

  typedef struct packed {
    logic             kind;
    wr_t              wr;
    logic             neg_i;
    logic             neg_j;
    logic [PPT_W-1:0] rem_i;
    logic [PPT_W-1:0] rem_j;
    logic [FN_W-1:0]  nq_i;
    logic [FN_W-1:0]  nq_j;
  } fr_t;

  typedef struct packed {
    logic                   kind;
    wr_t                    wr;
    logic signed [TI_W-1:0] ti;
    logic signed [TI_W-1:0] tj;
    logic signed [RR_W-1:0] ri;
    logic signed [RR_W-1:0] rj;
  } sg_t;

  typedef struct packed {
    logic                   kind;
    wr_t                    wr;
    logic                   upper;
    logic signed [RR_W-1:0] ri;
    logic signed [RR_W-1:0] rj;
    logic [MEM_AW-1:0]      addr_l;
    logic [MEM_AW-1:0]      addr_r;
    logic [MEM_AW-1:0]      addr_m;
    logic                   ok_l;
    logic                   ok_r;
    logic                   ok_m;
  } iss_t;

  typedef struct packed {
    logic                   upper;
    logic signed [RR_W-1:0] ri;
    logic signed [RR_W-1:0] rj;
    logic [HGT_W-1:0]       left;
    logic [HGT_W-1:0]       right;
    logic [HGT_W-1:0]       mid;
    logic                   ok_m;
  } cl_t;

  typedef struct packed {
    logic [PROD0_W-1:0]       p0;
    logic signed [PROD_W-1:0] p1;
    logic signed [PROD_W-1:0] p2;
  } mu_t;

  typedef struct packed {
    logic             neg;
    logic [PPT_W-1:0] rem;
    logic [BN_W-1:0]  nq;
  } bk_t;

  // Restoring division, DIV_STEP quotient bits; rem < d on entry and exit
  function automatic dstep_t div_step(input logic [PPT_W-1:0]    rem,
                                      input logic [DIV_STEP-1:0] nb,
                                      input logic [PPT_W-1:0]    d);
    logic [PPT_W:0]   t;
    logic [PPT_W-1:0] r;
    dstep_t           res;
    r     = rem;
    res.q = '0;
    for (int k = DIV_STEP - 1; k >= 0; k--) begin
      t = {r, nb[k]};
      if (t >= {1'b0, d}) begin
        t        = t - {1'b0, d};
        res.q[k] = 1'b1;
      end
      r = t[PPT_W-1:0];
    end
    res.rem = r;
    return res;
  endfunction

  function automatic logic [MEM_AW-1:0] grid_addr(input logic [TI_W-1:0] r,
                                                  input logic [TI_W-1:0] c);
    return MEM_AW'(32'(r) * GRID_SIZE + 32'(c));
  endfunction

  function automatic logic in_grid(input logic signed [TI_W-1:0] v);
    return !v[TI_W-1] && (32'($unsigned(v)) < GRID_SIZE);
  endfunction

endpackage

// ===== sv/hti_ram.sv =====
`timescale 1ns / 1ps

module hti_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/heightmap_triangle_interpolation.sv =====
`timescale 1ns / 1ps

// Triangulated heightmap lookup over a GRID_SIZE x GRID_SIZE grid of 16-bit heights held
// in one single-port RAM. A write item stores entry_height times the height scale register
// with a single RAM write. A query makes three RAM reads (left, right and middle corner),
// and the next query is issued only after them; writes flow at one per cycle while no query
// ahead of them is held. Order is strict: every access reaches the RAM in arrival order, so
// a query sees all earlier writes and no later one. The result of a query passes through a
// six-stage divider for the tile coordinates, the corner reads, the multiply and sum, and an
// eight-stage divider for the final division by the tile size. A stalled result holds the
// whole back end, and the stall backs up to the input. Grid contents are undefined until
// written; there is no clearing pass after reset. Change configuration only while the
// pipeline is empty.
module heightmap_triangle_interpolation (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_kind,
  input  logic signed [hti_pkg::PT_W-1:0]   in_point_i,
  input  logic signed [hti_pkg::PT_W-1:0]   in_point_j,
  input  logic [hti_pkg::IDX_W-1:0]         in_entry_row,
  input  logic [hti_pkg::IDX_W-1:0]         in_entry_col,
  input  logic [hti_pkg::BYTE_W-1:0]        in_entry_height,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [hti_pkg::ELEV_W-1:0] out_elevation,
  input  logic                              cfg_we,
  input  logic [hti_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [hti_pkg::CFG_DW-1:0]        cfg_wdata
);
  import hti_pkg::*;

  // Configuration
  logic [PPT_W-1:0]  ppt_r;
  logic [BYTE_W-1:0] pad_r;
  logic [BYTE_W-1:0] scale_r;
  logic [PPT_W-1:0]  div_d;

  // Front pipeline: tile divider and sign fix
  fr_t          fr_r   [0:FR_DIV];
  fr_t          fr_nxt [0:FR_DIV];
  logic [FR_DIV:0] fr_v_r;
  sg_t          sg_r, sg_nxt;
  logic         sg_v_r;
  logic         fr_adv;
  logic [PT_W-1:0] mag_i, mag_j;
  dstep_t       fs_i, fs_j;

  // Issue stage
  iss_t         iss_r, iss_nxt;
  logic         iss_v_r;
  step_t        step_r, step_nxt;
  logic         is_wr;
  logic         iss_done;
  logic         iss_free;
  logic signed [TI_W-1:0] r0, r1, c0, c1;
  logic         okr0, okr1, okc0, okc1;
  logic [HGT_W-1:0] left_r;

  // Grid RAM
  logic              ram_en;
  logic              ram_we;
  logic [MEM_AW-1:0] ram_addr;
  logic [HGT_W-1:0]  ram_rdata;

  // Corner collection
  cl_t          cl_r;
  logic         cl_v_r;
  logic         cl_wait_r;
  logic         cl_free;
  logic         cl_load;
  logic         cl_pop;

  // Back pipeline: products, sum, final divider, output
  logic         bk_adv;
  logic signed [DIFF_W-1:0] d_ml, d_rm, dif_a, dif_b;
  mu_t          mu_r, mu_nxt;
  logic         mu_v_r;
  logic signed [NUM_W-1:0] sum_r, sum_nxt;
  logic         sum_v_r;
  bk_t          bd_r   [0:BK_DIV];
  bk_t          bd_nxt [0:BK_DIV];
  logic [BK_DIV:0] bd_v_r;
  dstep_t       bs;
  logic [ELEV_W-1:0] quo;
  logic [ELEV_W-1:0] elev_nxt;
  logic         out_v_r;
  logic [ELEV_W-1:0] out_elev_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppt_r   <= PPT_W'(16);
      pad_r   <= '0;
      scale_r <= BYTE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PPT:   ppt_r   <= cfg_wdata[PPT_W-1:0];
        REG_PAD:   pad_r   <= cfg_wdata[BYTE_W-1:0];
        REG_SCALE: scale_r <= cfg_wdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  assign div_d = (ppt_r == '0) ? PPT_W'(1) : ppt_r;

  // ---------------------------------------------------------------- front
  always_comb begin
    mag_i = in_point_i[PT_W-1] ? $unsigned(-in_point_i) : $unsigned(in_point_i);
    mag_j = in_point_j[PT_W-1] ? $unsigned(-in_point_j) : $unsigned(in_point_j);

    fr_nxt[0].kind    = in_kind;
    fr_nxt[0].wr.ok   = (32'(in_entry_row) < GRID_SIZE) && (32'(in_entry_col) < GRID_SIZE);
    fr_nxt[0].wr.addr = grid_addr(TI_W'(in_entry_row), TI_W'(in_entry_col));
    fr_nxt[0].wr.data = HGT_W'(in_entry_height) * HGT_W'(scale_r);
    fr_nxt[0].neg_i   = in_point_i[PT_W-1];
    fr_nxt[0].neg_j   = in_point_j[PT_W-1];
    fr_nxt[0].rem_i   = '0;
    fr_nxt[0].rem_j   = '0;
    fr_nxt[0].nq_i    = FN_W'(mag_i);
    fr_nxt[0].nq_j    = FN_W'(mag_j);

    fs_i = '0;
    fs_j = '0;
    for (int k = 1; k <= FR_DIV; k++) begin
      fr_nxt[k]       = fr_r[k-1];
      fs_i            = div_step(fr_r[k-1].rem_i, fr_r[k-1].nq_i[FN_W-1 -: DIV_STEP], div_d);
      fs_j            = div_step(fr_r[k-1].rem_j, fr_r[k-1].nq_j[FN_W-1 -: DIV_STEP], div_d);
      fr_nxt[k].rem_i = fs_i.rem;
      fr_nxt[k].rem_j = fs_j.rem;
      fr_nxt[k].nq_i  = {fr_r[k-1].nq_i[FN_W-DIV_STEP-1:0], fs_i.q};
      fr_nxt[k].nq_j  = {fr_r[k-1].nq_j[FN_W-DIV_STEP-1:0], fs_j.q};
    end

    // Truncating division: quotient and remainder take the dividend's sign
    sg_nxt.kind = fr_r[FR_DIV].kind;
    sg_nxt.wr   = fr_r[FR_DIV].wr;
    sg_nxt.ti   = fr_r[FR_DIV].neg_i ? -$signed(fr_r[FR_DIV].nq_i) : $signed(fr_r[FR_DIV].nq_i);
    sg_nxt.tj   = fr_r[FR_DIV].neg_j ? -$signed(fr_r[FR_DIV].nq_j) : $signed(fr_r[FR_DIV].nq_j);
    sg_nxt.ri   = fr_r[FR_DIV].neg_i ? -$signed({1'b0, fr_r[FR_DIV].rem_i})
                                     :  $signed({1'b0, fr_r[FR_DIV].rem_i});
    sg_nxt.rj   = fr_r[FR_DIV].neg_j ? -$signed({1'b0, fr_r[FR_DIV].rem_j})
                                     :  $signed({1'b0, fr_r[FR_DIV].rem_j});
  end

  assign fr_adv   = !sg_v_r || iss_free;
  assign in_stall = !fr_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r <= '0;
      sg_v_r <= 1'b0;
    end else if (fr_adv) begin
      fr_v_r <= {fr_v_r[FR_DIV-1:0], in_valid};
      sg_v_r <= fr_v_r[FR_DIV];
    end
  end

  always_ff @(posedge clk) begin
    if (fr_adv) begin
      for (int k = 0; k <= FR_DIV; k++) begin
        fr_r[k] <= fr_nxt[k];
      end
      sg_r <= sg_nxt;
    end
  end

  // ---------------------------------------------------------------- issue
  always_comb begin
    r0   = sg_r.ti + $signed(TI_W'(pad_r));
    c0   = sg_r.tj + $signed(TI_W'(pad_r));
    r1   = r0 + $signed(TI_W'(1));
    c1   = c0 + $signed(TI_W'(1));
    okr0 = in_grid(r0);
    okr1 = in_grid(r1);
    okc0 = in_grid(c0);
    okc1 = in_grid(c1);

    iss_nxt.kind   = sg_r.kind;
    iss_nxt.wr     = sg_r.wr;
    iss_nxt.upper  = sg_r.ri <= sg_r.rj;
    iss_nxt.ri     = sg_r.ri;
    iss_nxt.rj     = sg_r.rj;
    iss_nxt.addr_l = grid_addr(r0, c0);
    iss_nxt.addr_r = grid_addr(r1, c1);
    iss_nxt.ok_l   = okr0 && okc0;
    iss_nxt.ok_r   = okr1 && okc1;
    if (sg_r.ri <= sg_r.rj) begin
      iss_nxt.addr_m = grid_addr(r0, c1);
      iss_nxt.ok_m   = okr0 && okc1;
    end else begin
      iss_nxt.addr_m = grid_addr(r1, c0);
      iss_nxt.ok_m   = okr1 && okc0;
    end
  end

  assign is_wr    = iss_r.kind == KIND_WRITE;
  assign cl_pop   = cl_v_r && !cl_wait_r && bk_adv;
  assign cl_free  = !cl_v_r || cl_pop;
  assign cl_load  = iss_v_r && !is_wr && (step_r == ST_MID) && cl_free;
  assign iss_done = iss_v_r && (is_wr || ((step_r == ST_MID) && cl_free));
  assign iss_free = !iss_v_r || iss_done;

  // The middle read is held back until the collect stage can take the item
  always_comb begin
    ram_we = is_wr;
    ram_en = iss_v_r && (is_wr ? iss_r.wr.ok : ((step_r != ST_MID) || cl_free));
    case (step_r)
      ST_LEFT:  ram_addr = iss_r.addr_l;
      ST_RIGHT: ram_addr = iss_r.addr_r;
      ST_MID:   ram_addr = iss_r.addr_m;
      default:  ram_addr = iss_r.addr_l;
    endcase
    if (is_wr) begin
      ram_addr = iss_r.wr.addr;
    end

    step_nxt = step_r;
    if (iss_v_r && !is_wr) begin
      case (step_r)
        ST_LEFT:  step_nxt = ST_RIGHT;
        ST_RIGHT: step_nxt = ST_MID;
        ST_MID:   step_nxt = cl_free ? ST_LEFT : ST_MID;
        default:  step_nxt = ST_LEFT;
      endcase
    end
  end

  hti_ram #(
    .WIDTH (HGT_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (iss_r.wr.data),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_v_r   <= 1'b0;
      step_r    <= ST_LEFT;
      cl_v_r    <= 1'b0;
      cl_wait_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (iss_free) begin
        iss_v_r <= sg_v_r;
      end
      if (cl_load) begin
        cl_v_r    <= 1'b1;
        cl_wait_r <= 1'b1;
      end else begin
        cl_wait_r <= 1'b0;
        if (cl_pop) begin
          cl_v_r <= 1'b0;
        end
      end
    end
  end

  // Corners outside the grid read as zero
  always_ff @(posedge clk) begin
    if (iss_free) begin
      iss_r <= iss_nxt;
    end
    if (iss_v_r && !is_wr && (step_r == ST_RIGHT)) begin
      left_r <= iss_r.ok_l ? ram_rdata : '0;
    end
    if (cl_load) begin
      cl_r.upper <= iss_r.upper;
      cl_r.ri    <= iss_r.ri;
      cl_r.rj    <= iss_r.rj;
      cl_r.left  <= left_r;
      cl_r.right <= iss_r.ok_r ? ram_rdata : '0;
      cl_r.ok_m  <= iss_r.ok_m;
    end
    if (cl_wait_r) begin
      cl_r.mid <= cl_r.ok_m ? ram_rdata : '0;
    end
  end

  // ---------------------------------------------------------------- back
  assign bk_adv = !out_v_r || !out_stall;

  always_comb begin
    d_ml  = $signed({1'b0, cl_r.mid}) - $signed({1'b0, cl_r.left});
    d_rm  = $signed({1'b0, cl_r.right}) - $signed({1'b0, cl_r.mid});
    dif_a = cl_r.upper ? d_rm : d_ml;
    dif_b = cl_r.upper ? d_ml : d_rm;

    mu_nxt.p0 = PROD0_W'(cl_r.left) * PROD0_W'(div_d);
    mu_nxt.p1 = PROD_W'(dif_a) * PROD_W'(cl_r.ri);
    mu_nxt.p2 = PROD_W'(dif_b) * PROD_W'(cl_r.rj);

    sum_nxt = $signed(NUM_W'(mu_r.p0)) + NUM_W'(mu_r.p1) + NUM_W'(mu_r.p2);

    bd_nxt[0].neg = sum_r[NUM_W-1];
    bd_nxt[0].rem = '0;
    bd_nxt[0].nq  = BN_W'($unsigned(sum_r[NUM_W-1] ? -sum_r : sum_r));

    bs = '0;
    for (int k = 1; k <= BK_DIV; k++) begin
      bd_nxt[k]     = bd_r[k-1];
      bs            = div_step(bd_r[k-1].rem, bd_r[k-1].nq[BN_W-1 -: DIV_STEP], div_d);
      bd_nxt[k].rem = bs.rem;
      bd_nxt[k].nq  = {bd_r[k-1].nq[BN_W-DIV_STEP-1:0], bs.q};
    end

    // Only the low result bits survive, so negate at result width
    quo      = bd_r[BK_DIV].nq[ELEV_W-1:0];
    elev_nxt = bd_r[BK_DIV].neg ? -quo : quo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_v_r  <= 1'b0;
      sum_v_r <= 1'b0;
      bd_v_r  <= '0;
      out_v_r <= 1'b0;
    end else if (bk_adv) begin
      mu_v_r  <= cl_v_r && !cl_wait_r;
      sum_v_r <= mu_v_r;
      bd_v_r  <= {bd_v_r[BK_DIV-1:0], sum_v_r};
      out_v_r <= bd_v_r[BK_DIV];
    end
  end

  always_ff @(posedge clk) begin
    if (bk_adv) begin
      mu_r  <= mu_nxt;
      sum_r <= sum_nxt;
      for (int k = 0; k <= BK_DIV; k++) begin
        bd_r[k] <= bd_nxt[k];
      end
      out_elev_r <= elev_nxt;
    end
  end

  assign out_valid     = out_v_r;
  assign out_elevation = $signed(out_elev_r);

`ifndef SYNTHESIS
  a_write_between_queries: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_en && ram_we) |-> (step_r == ST_LEFT))
    else $error("grid write issued in the middle of a query's corner reads");

  a_mid_capture_once: assert property (@(posedge clk) disable iff (!rst_n)
    cl_wait_r |=> !cl_wait_r)
    else $error("middle corner capture lasted more than one cycle");

  a_steps_only_for_query: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != ST_LEFT) |-> (iss_v_r && !is_wr))
    else $error("corner read sequence running without a query in the issue stage");

  a_collect_takes_query: assert property (@(posedge clk) disable iff (!rst_n)
    cl_load |=> (cl_v_r && cl_wait_r))
    else $error("collect stage not waiting for the middle corner after a load");
`endif

endmodule
